>>> rtl/assert_macros.svh
// assertion macros used by the sequencer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked assertion, off while reset is high
`define SQA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked assertion, checked during reset too
`define SQA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SQA_ASSERT(lbl, clk, rst, prop, msg)
`define SQA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/sqa_pkg.sv
// types and constants of the saturating q15/q31 alu
package sqa_pkg;

  localparam logic [3:0] KIND_ADD    = 4'd0;
  localparam logic [3:0] KIND_SUB    = 4'd1;
  localparam logic [3:0] KIND_MULT   = 4'd2;
  localparam logic [3:0] KIND_MULT_R = 4'd3;
  localparam logic [3:0] KIND_ABS    = 4'd4;
  localparam logic [3:0] KIND_DIV    = 4'd5;
  localparam logic [3:0] KIND_LMULT  = 4'd6;
  localparam logic [3:0] KIND_LADD   = 4'd7;
  localparam logic [3:0] KIND_LSUB   = 4'd8;
  localparam logic [3:0] KIND_NORM   = 4'd9;

  localparam logic [15:0] MIN16      = 16'h8000;
  localparam logic [31:0] MAX16_L    = 32'h0000_7FFF;
  localparam logic [31:0] MIN16_L    = 32'hFFFF_8000;
  localparam logic [31:0] MAX32      = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN32      = 32'h8000_0000;
  localparam logic [31:0] NEG_HALF   = 32'hC000_0000;
  localparam logic [32:0] ROUND_HALF = 33'd16384;
  localparam logic [3:0]  DIV_LAST_STEP = 4'd14;

  // saturation flags of the shared adder
  typedef struct packed {
    logic hi16;
    logic lo16;
    logic hi32;
    logic lo32;
  } sqa_sat_t;

  // finished result handed from the sequencer to the output stage
  typedef struct packed {
    logic        done;
    logic        invalid;
    logic [31:0] value;
  } sqa_res_t;

endpackage

>>> rtl/sqa_addsub.sv
// shared 33-bit adder/subtractor with saturation detect
module sqa_addsub import sqa_pkg::*; (
  input  logic [32:0] a,
  input  logic [32:0] b,
  input  logic        sub,
  output logic [32:0] sum,
  output sqa_sat_t    sat
);

  assign sum = a + (b ^ {33{sub}}) + {32'b0, sub};

  always_comb begin
    sat.hi16 = !sum[32] && (sum[31:15] != 17'h00000);
    sat.lo16 = sum[32] && (sum[31:15] != 17'h1FFFF);
    sat.hi32 = !sum[32] && sum[31];
    sat.lo32 = sum[32] && !sum[31];
  end

endmodule

>>> rtl/sqa_seq.sv
// operation sequencer: add, sub and abs, multiply, restoring divide and normalize steps
`include "assert_macros.svh"
module sqa_seq import sqa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        take,
  input  logic [3:0]  kind,
  input  logic [15:0] sa,
  input  logic [15:0] sb,
  input  logic [31:0] la,
  input  logic [31:0] lb,
  output logic        ready,
  output sqa_res_t    res
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_NORM = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]         state;
  logic [3:0]         kind_r;
  logic signed [31:0] prod;
  logic               mm_special;
  logic [14:0]        rem;
  logic [14:0]        den;
  logic [14:0]        quo;
  logic [3:0]         cnt;
  logic [31:0]        x;
  logic               sgn;
  logic [4:0]         n;
  logic [31:0]        val;
  logic               inv;

  logic [32:0] op_a;
  logic [32:0] op_b;
  logic        op_sub;
  logic [32:0] sum;
  sqa_sat_t    sat;
  logic [31:0] sat16_v;
  logic [31:0] sat32_v;
  logic        qbit;

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    case (state)
      ST_IDLE: begin
        case (kind)
          KIND_ADD: begin
            op_a = {{17{sa[15]}}, sa};
            op_b = {{17{sb[15]}}, sb};
          end
          KIND_SUB: begin
            op_a   = {{17{sa[15]}}, sa};
            op_b   = {{17{sb[15]}}, sb};
            op_sub = 1'b1;
          end
          KIND_ABS: begin
            op_b   = {{17{sa[15]}}, sa};
            op_sub = 1'b1;
          end
          KIND_DIV: begin
            // den - num, sign and zero give the validity checks
            op_a   = {{17{sb[15]}}, sb};
            op_b   = {{17{sa[15]}}, sa};
            op_sub = 1'b1;
          end
          KIND_LADD: begin
            op_a = {la[31], la};
            op_b = {lb[31], lb};
          end
          KIND_LSUB: begin
            op_a   = {la[31], la};
            op_b   = {lb[31], lb};
            op_sub = 1'b1;
          end
          default: begin
            op_a = '0;
          end
        endcase
      end
      ST_MUL: begin
        op_a = {prod[31], prod};
        op_b = (kind_r == KIND_MULT_R) ? ROUND_HALF : 33'd0;
      end
      ST_DIV: begin
        op_a   = {17'b0, rem, 1'b0};
        op_b   = {18'b0, den};
        op_sub = 1'b1;
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  sqa_addsub u_addsub (
    .a   (op_a),
    .b   (op_b),
    .sub (op_sub),
    .sum (sum),
    .sat (sat)
  );

  always_comb begin
    if (sat.hi16) begin
      sat16_v = MAX16_L;
    end else if (sat.lo16) begin
      sat16_v = MIN16_L;
    end else begin
      sat16_v = {{16{sum[15]}}, sum[15:0]};
    end
    if (sat.hi32) begin
      sat32_v = MAX32;
    end else if (sat.lo32) begin
      sat32_v = MIN32;
    end else begin
      sat32_v = sum[31:0];
    end
  end

  assign qbit = !sum[32];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            kind_r     <= kind;
            prod       <= $signed({{16{sa[15]}}, sa}) * $signed({{16{sb[15]}}, sb});
            mm_special <= (sa == MIN16) && (sb == MIN16);
            inv        <= 1'b0;
            state      <= ST_DONE;
            case (kind)
              KIND_ADD, KIND_SUB: begin
                val <= sat16_v;
              end
              KIND_ABS: begin
                if (sa == MIN16) begin
                  val <= MAX16_L;
                end else if (sa[15]) begin
                  val <= sum[31:0];
                end else begin
                  val <= {16'b0, sa};
                end
              end
              KIND_MULT, KIND_MULT_R, KIND_LMULT: begin
                state <= ST_MUL;
              end
              KIND_DIV: begin
                if (sa[15] || sum[32]) begin
                  inv <= 1'b1;
                  val <= '0;
                end else if (sum == 33'd0) begin
                  val <= MAX16_L;
                end else begin
                  rem   <= sa[14:0];
                  den   <= sb[14:0];
                  quo   <= '0;
                  cnt   <= '0;
                  state <= ST_DIV;
                end
              end
              KIND_LADD, KIND_LSUB: begin
                val <= sat32_v;
              end
              KIND_NORM: begin
                if (la == 32'd0 || la == MIN32 || la == NEG_HALF) begin
                  val <= '0;
                end else begin
                  x     <= la;
                  sgn   <= la[31];
                  n     <= '0;
                  state <= ST_NORM;
                end
              end
              default: begin
                val <= '0;
              end
            endcase
          end
        end
        ST_MUL: begin
          if (kind_r == KIND_LMULT) begin
            val <= mm_special ? MAX32 : {prod[30:0], 1'b0};
          end else begin
            val <= mm_special ? MAX16_L : {{16{sum[30]}}, sum[30:15]};
          end
          state <= ST_DONE;
        end
        ST_DIV: begin
          rem <= qbit ? sum[14:0] : {rem[13:0], 1'b0};
          quo <= {quo[13:0], qbit};
          cnt <= cnt + 4'd1;
          if (cnt == DIV_LAST_STEP) begin
            val   <= {17'b0, quo[13:0], qbit};
            state <= ST_DONE;
          end
        end
        ST_NORM: begin
          // two bit positions checked per cycle
          if (x[30] != sgn) begin
            val   <= {27'b0, n};
            state <= ST_DONE;
          end else if (x[29] != sgn) begin
            val   <= {27'b0, n + 5'd1};
            state <= ST_DONE;
          end else begin
            x <= {x[29:0], 2'b00};
            n <= n + 5'd2;
          end
        end
        ST_DONE: begin
          if (take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign ready       = (state == ST_IDLE);
  assign res.done    = (state == ST_DONE);
  assign res.invalid = inv;
  assign res.value   = val;

  `SQA_ASSERT(a_take_done, clk, rst, take |-> (state == ST_DONE), "result taken before done")
  `SQA_ASSERT(a_inv_zero, clk, rst, (res.done && res.invalid) |-> (res.value == 32'd0), "invalid with nonzero result")
  `SQA_ASSERT(a_norm_sign, clk, rst, (state == ST_NORM) |-> (x[31] == sgn), "normalize lost sign")
  `SQA_ASSERT(a_start_busy, clk, rst, start |=> !ready, "ready right after request")
  `SQA_ASSERT(a_div_cnt, clk, rst, (state == ST_DIV) |-> (cnt <= DIV_LAST_STEP), "divide step overrun")

endmodule

>>> rtl/saturating_q15_q31_alu.sv
// top level of the saturating q15/q31 fixed-point alu
// usage:
//   requests enter on the s_ group; s_tuser carries the operation kind, s_tdata
//   the operands. one result per request leaves on the m_ group: m_tdata is the
//   32-bit result (16-bit results sign-extended), m_tuser flags an invalid divide.
// steps from the accepting edge up to the output register and m_tvalid:
//   add, sub, abs, ladd, lsub, unused kinds: result formed on the accepting edge
//   mult, mult_r, lmult: registered 16x16 product, then round/shift
//   div: check on the accepting edge, 15 restoring steps on the shared adder
//   norm: two bit positions tested per cycle; zero and the two special values,
//   and an invalid or equal-operand divide, finish on the accepting edge
// requests: one at a time; s_tready is high only while the sequencer is idle,
//   so it rises again in the cycle after the previous result moves into the
//   output register
// reset: rst is synchronous, active high; it drops any request in flight and
//   clears m_tvalid, after which s_tready is high
// stall: a finished result sits in the output register until m_tready; the
//   sequencer can take the next request meanwhile and holds its own result
//   until the output register frees up
module saturating_q15_q31_alu import sqa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // short_a[15:0], short_b[31:16], long_a[63:32], long_b[95:64]
  input  logic [3:0]  s_tuser,   // kind[3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // result[31:0]
  output logic [0:0]  m_tuser    // invalid[0]
);

  logic     start;
  logic     take;
  sqa_res_t res;

  // a request starts only when the sequencer is idle
  assign start = s_tvalid && s_tready;

  sqa_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .take  (take),
    .kind  (s_tuser),
    .sa    (s_tdata[15:0]),
    .sb    (s_tdata[31:16]),
    .la    (s_tdata[63:32]),
    .lb    (s_tdata[95:64]),
    .ready (s_tready),
    .res   (res)
  );

  // move a finished result when the output register is empty or draining
  assign take = res.done && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata    <= res.value;
      m_tuser[0] <= res.invalid;
    end
  end

endmodule
